// ===== sv/mfsbd_pkg.sv =====
// ----------------------------------------------------------------------------
// mfsbd_pkg
// Shared types, constants and the bitrate table for the frame sync detector.
// ----------------------------------------------------------------------------
package mfsbd_pkg;

    // Default width of the byte position counter
    localparam int POSITION_BITS_DEF = 29;

    // Width of the tag skip offset (four 7-bit synchsafe digits plus ten)
    localparam int OFFSET_BITS = 29;

    // Entries in the queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // Configuration register indexes
    localparam int CFG_INDEX_BITS = 2;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_DEFAULT_RATE = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_MIN_RATE     = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_MAX_RATE     = 2'd2;

    // Register reset values
    localparam logic [15:0] DEFAULT_RATE_RESET = 16'd12000;
    localparam logic [15:0] MIN_RATE_RESET     = 16'd4000;
    localparam logic [15:0] MAX_RATE_RESET     = 16'd64000;

    // Bytes per second for one kbps
    localparam logic [15:0] BYTES_PER_KBPS = 16'd125;

    // Tag prefix bytes
    localparam logic [15:0] TAG_PREFIX_HEAD = 16'h4944;
    localparam logic [7:0]  TAG_PREFIX_TAIL = 8'h33;

    // Header field codes
    localparam logic [1:0] VER_RESERVED = 2'd1;
    localparam logic [1:0] VER_MPEG1    = 2'd3;
    localparam logic [1:0] LAYER_RSVD   = 2'd0;
    localparam logic [1:0] LAYER_I      = 2'd3;
    localparam logic [1:0] LAYER_II     = 2'd2;
    localparam logic [3:0] IDX_FREE     = 4'd0;
    localparam logic [3:0] IDX_BAD      = 4'd15;

    localparam logic [8:0] KBPS_TABLE [2][3][16] = '{
        '{
            '{9'd0, 9'd32, 9'd64, 9'd96, 9'd128, 9'd160, 9'd192, 9'd224,
              9'd256, 9'd288, 9'd320, 9'd352, 9'd384, 9'd416, 9'd448, 9'd0},
            '{9'd0, 9'd32, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96, 9'd112,
              9'd128, 9'd160, 9'd192, 9'd224, 9'd256, 9'd320, 9'd384, 9'd0},
            '{9'd0, 9'd32, 9'd40, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96,
              9'd112, 9'd128, 9'd160, 9'd192, 9'd224, 9'd256, 9'd320, 9'd0}
        },
        '{
            '{9'd0, 9'd32, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96, 9'd112,
              9'd128, 9'd144, 9'd160, 9'd176, 9'd192, 9'd224, 9'd256, 9'd0},
            '{9'd0, 9'd8, 9'd16, 9'd24, 9'd32, 9'd40, 9'd48, 9'd56,
              9'd64, 9'd80, 9'd96, 9'd112, 9'd128, 9'd144, 9'd160, 9'd0},
            '{9'd0, 9'd8, 9'd16, 9'd24, 9'd32, 9'd40, 9'd48, 9'd56,
              9'd64, 9'd80, 9'd96, 9'd112, 9'd128, 9'd144, 9'd160, 9'd0}
        }
    };

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } byte_item_t;

    typedef struct packed {
        logic [15:0] rate_bytes_per_sec;
        logic        header_found;
        logic [8:0]  table_kbps;
    } rate_item_t;

    // Work handed from front to back
    typedef struct packed {
        logic       found;
        logic [8:0] kbps;
    } job_t;

    typedef struct packed {
        logic [15:0] default_rate;
        logic [15:0] min_rate;
        logic [15:0] max_rate;
    } cfg_t;

    // Table kbps for a valid header, zero otherwise
    function automatic logic [8:0] header_kbps(input logic [31:0] hdr);
        logic [1:0] ver;
        logic [1:0] lay;
        logic [3:0] idx;
        logic       grp;
        logic [1:0] li;
        logic [8:0] res;
        ver = hdr[20:19];
        lay = hdr[18:17];
        idx = hdr[15:12];
        grp = (ver == VER_MPEG1) ? 1'b0 : 1'b1;
        li  = (lay == LAYER_I) ? 2'd0 : ((lay == LAYER_II) ? 2'd1 : 2'd2);
        if ((&hdr[31:21]) == 1'b0 || ver == VER_RESERVED || lay == LAYER_RSVD
            || idx == IDX_FREE || idx == IDX_BAD)
        begin
            res = 9'd0;
        end
        else
        begin
            res = KBPS_TABLE[grp][li][idx];
        end
        return res;
    endfunction

endpackage

// ===== sv/mp3_frame_sync_bitrate_detector.sv =====
// ----------------------------------------------------------------------------
// mp3_frame_sync_bitrate_detector
// Finds the first MPEG audio frame header in a byte stream and reports its rate.
// ----------------------------------------------------------------------------
// Feed the file one byte per transaction on the byte channel, marking the final
// byte with last_byte. The block takes one byte every clock cycle; the byte
// channel stalls only when the two-entry job queue is full, which happens only
// while a finished result is held in the output register by rate_stall. Each
// file yields exactly one result transaction: the first valid frame header
// after any ID3 tag (its kbps times 125, clamped to min_rate then max_rate),
// the early header of a tagged file that ends before its last size byte, or
// default_rate when the file ends with no header. A result enters the queue
// when the byte deciding it is accepted, then moves into the output register;
// the latency is set by the queue and the single rate stage behind it.
// Write the configuration registers only while no file is in flight.
// ----------------------------------------------------------------------------
module mp3_frame_sync_bitrate_detector #(
    parameter int POSITION_BITS = mfsbd_pkg::POSITION_BITS_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    // Byte channel
    input  logic                                  byte_valid,
    output logic                                  byte_stall,
    input  mfsbd_pkg::byte_item_t                 byte_item,
    // Result channel
    output logic                                  rate_valid,
    input  logic                                  rate_stall,
    output mfsbd_pkg::rate_item_t                 rate_item,
    // Configuration write port
    input  logic                                  cfg_write,
    input  logic [mfsbd_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  logic [15:0]                           cfg_data
);
    import mfsbd_pkg::*;

    cfg_t cfg_reg;

    logic byte_accept;
    logic q_full;
    logic push;
    job_t push_job;
    logic job_valid;
    job_t job;
    logic pop;

    // Hold the byte channel whenever the queue cannot take another job
    assign byte_stall  = q_full;
    assign byte_accept = byte_valid && !q_full;

    // Configuration registers; indexes beyond the list are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.default_rate <= DEFAULT_RATE_RESET;
            cfg_reg.min_rate     <= MIN_RATE_RESET;
            cfg_reg.max_rate     <= MAX_RATE_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_DEFAULT_RATE: cfg_reg.default_rate <= cfg_data;
                CFG_MIN_RATE:     cfg_reg.min_rate     <= cfg_data;
                CFG_MAX_RATE:     cfg_reg.max_rate     <= cfg_data;
                default:          ;
            endcase
        end
    end

    // Front: stream tracking, tag skip and header spotting
    mfsbd_front #(
        .POSITION_BITS (POSITION_BITS)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .accept   (byte_accept),
        .item     (byte_item),
        .push     (push),
        .push_job (push_job)
    );

    // Queue: decouple the front from a stalled result channel
    mfsbd_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_job  (push_job),
        .full      (q_full),
        .job_valid (job_valid),
        .pop       (pop),
        .job       (job)
    );

    // Back: rate scaling, clamping and the output register
    mfsbd_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .job_valid  (job_valid),
        .job        (job),
        .pop        (pop),
        .rate_valid (rate_valid),
        .rate_stall (rate_stall),
        .rate_item  (rate_item)
    );

endmodule

// ===== sv/mfsbd_queue.sv =====
// ----------------------------------------------------------------------------
// mfsbd_queue
// Short first-in first-out queue of jobs between front and back.
// ----------------------------------------------------------------------------
module mfsbd_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  mfsbd_pkg::job_t push_job,
    output logic            full,
    output logic            job_valid,
    input  logic            pop,
    output mfsbd_pkg::job_t job
);
    import mfsbd_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    job_t             slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full      = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign job_valid = (count_reg != '0);
    assign job       = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Payload slots need no reset
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

// ===== sv/mfsbd_front.sv =====
// ----------------------------------------------------------------------------
// mfsbd_front
// Tracks the byte stream, skips the tag, spots the first frame header.
// ----------------------------------------------------------------------------
module mfsbd_front #(
    parameter int POSITION_BITS = mfsbd_pkg::POSITION_BITS_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   accept,
    input  mfsbd_pkg::byte_item_t  item,
    output logic                   push,
    output mfsbd_pkg::job_t        push_job
);
    import mfsbd_pkg::*;

    localparam int CMP_W = (POSITION_BITS > OFFSET_BITS) ? POSITION_BITS : OFFSET_BITS;

    logic [POSITION_BITS-1:0] pos_reg, pos_next;
    logic [23:0]              win_reg, win_next;
    logic                     tag_reg, tag_next;
    logic [OFFSET_BITS-1:0]   offset_reg, offset_next;
    logic                     given_reg, given_next;
    logic                     early_valid_reg, early_valid_next;
    logic [8:0]               early_kbps_reg, early_kbps_next;

    logic [7:0]  b;
    logic [8:0]  kbps;
    logic        emit_now;
    logic        past_offset;
    logic [CMP_W-1:0] scan_pos;

    assign b        = item.data_byte;
    assign kbps     = header_kbps({win_reg, b});
    assign scan_pos = CMP_W'(pos_reg) - CMP_W'(3);

    always_comb
    begin
        tag_next         = tag_reg;
        offset_next      = offset_reg;
        early_valid_next = early_valid_reg;
        early_kbps_next  = early_kbps_reg;
        emit_now         = 1'b0;
        past_offset      = 1'b0;

        if (!given_reg)
        begin
            if (pos_reg == POSITION_BITS'(2) && win_reg[15:0] == TAG_PREFIX_HEAD
                && b == TAG_PREFIX_TAIL)
            begin
                tag_next = 1'b1;
            end
            // Gather the synchsafe size, seven bits a byte
            if (tag_next && pos_reg >= POSITION_BITS'(6) && pos_reg <= POSITION_BITS'(9))
            begin
                offset_next = {offset_reg[OFFSET_BITS-8:0], b[6:0]};
            end
            if (tag_next && pos_reg == POSITION_BITS'(9))
            begin
                offset_next      = offset_next + OFFSET_BITS'(10);
                early_valid_next = 1'b0;
            end
            past_offset = (scan_pos >= CMP_W'(offset_next));
            if (pos_reg >= POSITION_BITS'(3) && kbps != 9'd0)
            begin
                if (!tag_next)
                begin
                    emit_now = 1'b1;
                end
                else if (pos_reg <= POSITION_BITS'(8))
                begin
                    if (!early_valid_reg)
                    begin
                        early_valid_next = 1'b1;
                        early_kbps_next  = kbps;
                    end
                end
                else if (pos_reg >= POSITION_BITS'(10) && past_offset)
                begin
                    emit_now = 1'b1;
                end
            end
        end

        given_next = given_reg | emit_now;
        win_next   = {win_reg[15:0], b};
        pos_next   = (&pos_reg) ? pos_reg : pos_reg + 1'b1;
    end

    // One job per file: the header when found, else the held or default answer
    assign push = accept && !given_reg && (emit_now || item.last_byte);

    always_comb
    begin
        if (emit_now)
        begin
            push_job = '{found: 1'b1, kbps: kbps};
        end
        else if (early_valid_next)
        begin
            push_job = '{found: 1'b1, kbps: early_kbps_next};
        end
        else
        begin
            push_job = '{found: 1'b0, kbps: 9'd0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg         <= '0;
            win_reg         <= '0;
            tag_reg         <= 1'b0;
            offset_reg      <= '0;
            given_reg       <= 1'b0;
            early_valid_reg <= 1'b0;
            early_kbps_reg  <= '0;
        end
        else if (accept)
        begin
            if (item.last_byte)
            begin
                pos_reg         <= '0;
                win_reg         <= '0;
                tag_reg         <= 1'b0;
                offset_reg      <= '0;
                given_reg       <= 1'b0;
                early_valid_reg <= 1'b0;
                early_kbps_reg  <= '0;
            end
            else
            begin
                pos_reg         <= pos_next;
                win_reg         <= win_next;
                tag_reg         <= tag_next;
                offset_reg      <= offset_next;
                given_reg       <= given_next;
                early_valid_reg <= early_valid_next;
                early_kbps_reg  <= early_kbps_next;
            end
        end
    end

endmodule

// ===== sv/mfsbd_back.sv =====
// ----------------------------------------------------------------------------
// mfsbd_back
// Turns a job into a clamped byte rate and holds it in the output register.
// ----------------------------------------------------------------------------
module mfsbd_back (
    input  logic                  clk,
    input  logic                  rst_n,
    input  mfsbd_pkg::cfg_t       cfg,
    input  logic                  job_valid,
    input  mfsbd_pkg::job_t       job,
    output logic                  pop,
    output logic                  rate_valid,
    input  logic                  rate_stall,
    output mfsbd_pkg::rate_item_t rate_item
);
    import mfsbd_pkg::*;

    logic       out_valid_reg, out_valid_next;
    rate_item_t out_reg, out_next;
    logic [15:0] product;
    logic [15:0] clamped;

    // kbps tops out at 448, so the product fits in 16 bits
    assign product = 16'(job.kbps) * BYTES_PER_KBPS;

    always_comb
    begin
        if (product < cfg.min_rate)
        begin
            clamped = cfg.min_rate;
        end
        else if (product > cfg.max_rate)
        begin
            clamped = cfg.max_rate;
        end
        else
        begin
            clamped = product;
        end
    end

    assign pop = job_valid && (!out_valid_reg || !rate_stall);

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        if (out_valid_reg && !rate_stall)
        begin
            out_valid_next = 1'b0;
        end
        if (pop)
        begin
            out_valid_next = 1'b1;
            if (job.found)
            begin
                out_next = '{rate_bytes_per_sec: clamped, header_found: 1'b1,
                             table_kbps: job.kbps};
            end
            else
            begin
                out_next = '{rate_bytes_per_sec: cfg.default_rate, header_found: 1'b0,
                             table_kbps: 9'd0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign rate_valid = out_valid_reg;
    assign rate_item  = out_reg;

endmodule

// ===== tb/sv/mp3_frame_sync_bitrate_detector_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// mp3_frame_sync_bitrate_detector_tb
// Self-checking bench for the frame sync and bitrate detector.
// ----------------------------------------------------------------------------
// Streams whole files through the byte channel: a short hand-built set first,
// then random files under several rate register settings. Most random files
// are well formed (ID3 tags of random size, early headers, truncated tags,
// valid and near-miss frame headers), with noise and broken prefixes mixed in.
// A tracker object predicts the one rate transaction each file yields and
// compares every result transaction field by field against it. Both channels
// idle and stall at random, with stretches of full throughput.
// ----------------------------------------------------------------------------
module mp3_frame_sync_bitrate_detector_tb;

    import mfsbd_pkg::*;

    localparam int POS_W       = POSITION_BITS_DEF;
    localparam int SETTLE      = 8;
    localparam int CYCLE_LIMIT = 400000;
    localparam int PHASE_BYTES = 195;

    // ------------------------------------------------------------------------
    // Rate tracker: own copy of the detector state and rate registers, and
    // the queue of rate transactions still owed by the block.
    // ------------------------------------------------------------------------
    class frame_rate_tracker;
        rate_item_t          pending_rates[$];
        int unsigned         mismatches;
        logic [15:0]         default_rate;
        logic [15:0]         min_rate;
        logic [15:0]         max_rate;
        logic [POS_W-1:0]    byte_pos;
        logic [23:0]         window;
        logic [OFFSET_BITS-1:0] tag_offset;
        bit                  tag_seen;
        bit                  answered;
        bit                  early_valid;
        logic [8:0]          early_kbps;

        function new();
            default_rate = DEFAULT_RATE_RESET;
            min_rate     = MIN_RATE_RESET;
            max_rate     = MAX_RATE_RESET;
            mismatches   = 0;
            clear_file();
        endfunction

        function void clear_file();
            byte_pos    = '0;
            window      = '0;
            tag_offset  = '0;
            tag_seen    = 1'b0;
            answered    = 1'b0;
            early_valid = 1'b0;
            early_kbps  = '0;
        endfunction

        function void write_reg(logic [CFG_INDEX_BITS-1:0] idx, logic [15:0] val);
            case (idx)
                CFG_DEFAULT_RATE: default_rate = val;
                CFG_MIN_RATE:     min_rate     = val;
                CFG_MAX_RATE:     max_rate     = val;
                default:          ;
            endcase
        endfunction

        function int pending_count();
            return pending_rates.size();
        endfunction

        // Bitrate of a 32-bit header word, zero when the word is no header
        function logic [8:0] header_bitrate(logic [31:0] hdr);
            logic [1:0] ver;
            logic [1:0] lay;
            logic [3:0] idx;
            logic [8:0] row [16];
            logic [8:0] res;
            ver = hdr[20:19];
            lay = hdr[18:17];
            idx = hdr[15:12];
            res = '0;
            if (hdr[31:21] == 11'h7ff && ver != VER_RESERVED && lay != LAYER_RSVD
                && idx != IDX_FREE && idx != IDX_BAD)
            begin
                if (ver == VER_MPEG1)
                begin
                    case (lay)
                        LAYER_I:  row = '{0, 32, 64, 96, 128, 160, 192, 224, 256, 288,
                                          320, 352, 384, 416, 448, 0};
                        LAYER_II: row = '{0, 32, 48, 56, 64, 80, 96, 112, 128, 160,
                                          192, 224, 256, 320, 384, 0};
                        default:  row = '{0, 32, 40, 48, 56, 64, 80, 96, 112, 128,
                                          160, 192, 224, 256, 320, 0};
                    endcase
                end
                else
                begin
                    case (lay)
                        LAYER_I:  row = '{0, 32, 48, 56, 64, 80, 96, 112, 128, 144,
                                          160, 176, 192, 224, 256, 0};
                        default:  row = '{0, 8, 16, 24, 32, 40, 48, 56, 64, 80,
                                          96, 112, 128, 144, 160, 0};
                    endcase
                end
                res = row[idx];
            end
            return res;
        endfunction

        // Clamp order matters when the limits cross: floor first, then ceiling
        function rate_item_t found_rate(logic [8:0] kbps);
            rate_item_t  r;
            int unsigned rate;
            rate = kbps * BYTES_PER_KBPS;
            if (rate < min_rate)
                rate = min_rate;
            else if (rate > max_rate)
                rate = max_rate;
            r.rate_bytes_per_sec = rate[15:0];
            r.header_found       = 1'b1;
            r.table_kbps         = kbps;
            return r;
        endfunction

        function void note_byte(byte_item_t it);
            logic [7:0] b;
            logic [8:0] kbps;
            rate_item_t r;
            bit         hit;
            b   = it.data_byte;
            hit = 1'b0;
            if (!answered)
            begin
                if (byte_pos == 2 && window[15:0] == TAG_PREFIX_HEAD && b == TAG_PREFIX_TAIL)
                    tag_seen = 1'b1;
                if (tag_seen && byte_pos >= 6 && byte_pos <= 9)
                    tag_offset = {tag_offset[OFFSET_BITS-8:0], b[6:0]};
                if (tag_seen && byte_pos == 9)
                begin
                    tag_offset  = tag_offset + OFFSET_BITS'(10);
                    early_valid = 1'b0;
                end
                if (byte_pos >= 3)
                begin
                    kbps = header_bitrate({window, b});
                    if (kbps != 0)
                    begin
                        if (!tag_seen)
                            hit = 1'b1;
                        else if (byte_pos <= 8)
                        begin
                            if (!early_valid)
                            begin
                                early_valid = 1'b1;
                                early_kbps  = kbps;
                            end
                        end
                        else if (byte_pos >= 10 && (byte_pos - 3) >= tag_offset)
                            hit = 1'b1;
                        if (hit)
                        begin
                            pending_rates.push_back(found_rate(kbps));
                            answered = 1'b1;
                        end
                    end
                end
            end
            window = {window[15:0], b};
            if (byte_pos != '1)
                byte_pos = byte_pos + 1'b1;
            if (it.last_byte)
            begin
                if (!answered)
                begin
                    if (early_valid)
                        pending_rates.push_back(found_rate(early_kbps));
                    else
                    begin
                        r.rate_bytes_per_sec = default_rate;
                        r.header_found       = 1'b0;
                        r.table_kbps         = '0;
                        pending_rates.push_back(r);
                    end
                end
                clear_file();
            end
        endfunction

        task report(string msg);
            mismatches++;
            $display("MISMATCH at %0t: %s", $realtime, msg);
        endtask

        task check_rate(rate_item_t got);
            rate_item_t want;
            if (pending_rates.size() == 0)
                report($sformatf("unexpected rate transaction rate=%0d found=%0b kbps=%0d",
                                 got.rate_bytes_per_sec, got.header_found, got.table_kbps));
            else
            begin
                want = pending_rates.pop_front();
                if (got.rate_bytes_per_sec !== want.rate_bytes_per_sec)
                    report($sformatf("rate_bytes_per_sec got %0d want %0d",
                                     got.rate_bytes_per_sec, want.rate_bytes_per_sec));
                if (got.header_found !== want.header_found)
                    report($sformatf("header_found got %0b want %0b",
                                     got.header_found, want.header_found));
                if (got.table_kbps !== want.table_kbps)
                    report($sformatf("table_kbps got %0d want %0d",
                                     got.table_kbps, want.table_kbps));
            end
        endtask
    endclass

    // ------------------------------------------------------------------------
    // Block signals
    // ------------------------------------------------------------------------
    logic                      clk;
    logic                      rst_n;
    logic                      byte_valid;
    logic                      byte_stall;
    byte_item_t                byte_item;
    logic                      rate_valid;
    logic                      rate_stall;
    rate_item_t                rate_item;
    logic                      cfg_write;
    logic [CFG_INDEX_BITS-1:0] cfg_index;
    logic [15:0]               cfg_data;

    frame_rate_tracker tracker;
    logic [7:0]        file_bytes[$];   // file under construction
    int                sink_mode;       // idling pattern of the result side
    int unsigned       cycle_count;

    mp3_frame_sync_bitrate_detector dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_valid),
        .byte_stall (byte_stall),
        .byte_item  (byte_item),
        .rate_valid (rate_valid),
        .rate_stall (rate_stall),
        .rate_item  (rate_item),
        .cfg_write  (cfg_write),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Watchdog: a hung handshake ends the run as a failure
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Idle pattern: mode 0 runs flat out, mode 1 waits a random gap before every
    // transaction, mode 2 mostly runs flat out with the odd long gap.
    // ------------------------------------------------------------------------
    function automatic int draw_wait(int mode);
        int n;
        case (mode)
            0:       n = 0;
            1:       n = $urandom_range(0, 14);
            default: n = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 14) : 0;
        endcase
        return n;
    endfunction

    // Offer one byte transaction and hold it until the block takes it.
    // Inputs move only on the falling edge; acceptance is seen at the rising.
    task automatic send_byte(input byte_item_t it, input int mode);
        int gap;
        gap = draw_wait(mode);
        @(negedge clk);
        if (gap > 0)
        begin
            byte_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        byte_valid = 1'b1;
        byte_item  = it;
        @(posedge clk);
        while (byte_stall)
            @(posedge clk);
        tracker.note_byte(it);
    endtask

    // Drop valid and hold off until every owed rate transaction has arrived
    task automatic hold_until_drained();
        @(negedge clk);
        byte_valid = 1'b0;
        while (tracker.pending_count() != 0)
            @(posedge clk);
    endtask

    // Send the built file, marking its final byte; pick fresh idle patterns
    task automatic send_file();
        byte_item_t it;
        int         mode;
        mode      = $urandom_range(0, 2);
        sink_mode = $urandom_range(0, 2);
        for (int i = 0; i < file_bytes.size(); i++)
        begin
            it.data_byte = file_bytes[i];
            it.last_byte = (i == file_bytes.size() - 1);
            send_byte(it, mode);
            // Now and then hold the sender back mid-file until results drain
            if ($urandom_range(0, 199) == 0)
                hold_until_drained();
        end
    endtask

    // Write all three rate registers while the block has nothing in flight.
    // The last byte of a file that already answered yields nothing, so let it
    // settle through the pipe before touching the registers.
    task automatic apply_rates(input logic [15:0] dflt, input logic [15:0] lo,
                               input logic [15:0] hi);
        hold_until_drained();
        repeat (SETTLE) @(negedge clk);
        cfg_write = 1'b1;
        cfg_index = CFG_DEFAULT_RATE;
        cfg_data  = dflt;
        tracker.write_reg(CFG_DEFAULT_RATE, dflt);
        @(negedge clk);
        cfg_index = CFG_MIN_RATE;
        cfg_data  = lo;
        tracker.write_reg(CFG_MIN_RATE, lo);
        @(negedge clk);
        cfg_index = CFG_MAX_RATE;
        cfg_data  = hi;
        tracker.write_reg(CFG_MAX_RATE, hi);
        @(negedge clk);
        cfg_write = 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // File builders
    // ------------------------------------------------------------------------
    function automatic logic [7:0] noise_byte();
        logic [7:0] b;
        case ($urandom_range(0, 3))
            0:       b = 8'hff;
            1:       b = 8'($urandom_range(8'he0, 8'hff));
            default: b = 8'($urandom);
        endcase
        return b;
    endfunction

    // Mostly valid headers with random content; the rest broken somewhere
    function automatic logic [31:0] random_header();
        logic [1:0]  ver;
        logic [1:0]  lay;
        logic [3:0]  idx;
        logic [31:0] hdr;
        ver = 2'($urandom);
        lay = 2'($urandom);
        idx = 4'($urandom);
        if ($urandom_range(0, 3) != 0)
        begin
            while (ver == VER_RESERVED)
                ver = 2'($urandom);
            while (lay == LAYER_RSVD)
                lay = 2'($urandom);
            if (idx == IDX_FREE || idx == IDX_BAD)
                idx = 4'($urandom_range(1, 14));
        end
        hdr = {11'h7ff, ver, lay, 1'($urandom), idx, 4'($urandom), 8'($urandom)};
        if ($urandom_range(0, 7) == 0)
            hdr[31:21] = hdr[31:21] ^ (11'd1 << $urandom_range(0, 10));
        return hdr;
    endfunction

    task automatic push_word(input logic [31:0] w);
        file_bytes.push_back(w[31:24]);
        file_bytes.push_back(w[23:16]);
        file_bytes.push_back(w[15:8]);
        file_bytes.push_back(w[7:0]);
    endtask

    task automatic push_noise(input int n);
        repeat (n) file_bytes.push_back(noise_byte());
    endtask

    // Untagged file: noise, a header, a short tail
    task automatic build_plain_file();
        file_bytes = {};
        push_noise($urandom_range(0, 6));
        push_word(random_header());
        push_noise($urandom_range(0, 4));
    endtask

    // ID3-tagged file: random synchsafe size, optional early header, optional
    // truncation inside the tag, then padding up to a small size and a header
    task automatic build_tagged_file();
        int          size;
        int          cut;
        int          p;
        logic [31:0] off;
        logic [31:0] hdr;
        file_bytes = {};
        file_bytes.push_back(TAG_PREFIX_HEAD[15:8]);
        file_bytes.push_back(TAG_PREFIX_HEAD[7:0]);
        file_bytes.push_back(TAG_PREFIX_TAIL);
        push_noise(3);
        case ($urandom_range(0, 5))
            0, 1, 2, 3: size = $urandom_range(0, 24);
            4:          size = $urandom_range(25, 60);
            default:    size = $urandom_range(0, 32'h0fff_ffff);
        endcase
        // Four 7-bit digits; the top bit of each is don't-care, so toggle it
        for (int i = 3; i >= 0; i--)
            file_bytes.push_back({1'($urandom_range(0, 3) == 0), 7'(size >> (7 * i))});
        if ($urandom_range(0, 3) == 0)
        begin
            hdr = random_header();
            p   = $urandom_range(3, 5);
            for (int i = 0; i < 4; i++)
                file_bytes[p + i] = hdr[31 - 8 * i -: 8];
        end
        off = {file_bytes[6][6:0], file_bytes[7][6:0], file_bytes[8][6:0], file_bytes[9][6:0]};
        if ($urandom_range(0, 5) == 0)
        begin
            // End inside the tag: an early header may then be reported
            cut = $urandom_range(4, 11);
            if (cut <= 10)
            begin
                while (file_bytes.size() > cut)
                    void'(file_bytes.pop_back());
                return;
            end
        end
        if (off <= 60)
        begin
            push_noise(off);
            push_word(random_header());
            push_noise($urandom_range(0, 3));
        end
        else
        begin
            push_noise($urandom_range(0, 4));
            if ($urandom_range(0, 1) == 0)
                push_word(random_header());
        end
    endtask

    // Noise only, rich in sync-like bytes
    task automatic build_noise_file();
        file_bytes = {};
        push_noise($urandom_range(1, 10));
    endtask

    // Broken tag prefixes: the tag must not be honoured
    task automatic build_near_tag_file();
        file_bytes = {};
        case ($urandom_range(0, 2))
            0:
            begin
                file_bytes.push_back(TAG_PREFIX_HEAD[15:8]);
                file_bytes.push_back(TAG_PREFIX_HEAD[7:0]);
                file_bytes.push_back(TAG_PREFIX_TAIL ^ 8'(1 << $urandom_range(0, 7)));
            end
            1:
            begin
                file_bytes.push_back(TAG_PREFIX_HEAD[15:8] ^ 8'(1 << $urandom_range(0, 7)));
                file_bytes.push_back(TAG_PREFIX_HEAD[7:0]);
                file_bytes.push_back(TAG_PREFIX_TAIL);
            end
            default:
            begin
                file_bytes.push_back(8'($urandom));
                file_bytes.push_back(TAG_PREFIX_HEAD[15:8]);
                file_bytes.push_back(TAG_PREFIX_HEAD[7:0]);
                file_bytes.push_back(TAG_PREFIX_TAIL);
            end
        endcase
        push_noise($urandom_range(0, 8));
        push_word(random_header());
        push_noise($urandom_range(0, 2));
    endtask

    // Random files until the byte budget of the phase is spent
    task automatic run_random_files(input int budget);
        int sent;
        int pick;
        sent = 0;
        while (sent < budget)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 35)
                build_plain_file();
            else if (pick < 75)
                build_tagged_file();
            else if (pick < 90)
                build_noise_file();
            else
                build_near_tag_file();
            send_file();
            sent += file_bytes.size();
        end
    endtask

    // ------------------------------------------------------------------------
    // Result side: stall for a drawn number of cycles, then take the next
    // rate transaction and hand it to the tracker.
    // ------------------------------------------------------------------------
    initial
    begin : rate_sink
        int n;
        @(posedge rst_n);
        forever
        begin
            n = draw_wait(sink_mode);
            @(negedge clk);
            rate_stall = (n > 0);
            if (n > 0)
            begin
                repeat (n) @(negedge clk);
                rate_stall = 1'b0;
            end
            @(posedge clk);
            while (!rate_valid)
                @(posedge clk);
            tracker.check_rate(rate_item);
        end
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin : main_seq
        logic [15:0] lo;
        rst_n       = 1'b0;
        byte_valid  = 1'b0;
        byte_item   = '0;
        rate_stall  = 1'b0;
        cfg_write   = 1'b0;
        cfg_index   = CFG_DEFAULT_RATE;
        cfg_data    = '0;
        sink_mode   = 0;
        cycle_count = 0;
        tracker     = new();
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed files under the reset register values.
        // Header at the very start, then a byte after the answer.
        file_bytes = '{8'hff, 8'hfb, 8'h90, 8'h64, 8'h00};
        send_file();
        // Tagged file ending inside the tag: the early header is reported
        // (its low rate also hits the floor)
        file_bytes = '{8'h49, 8'h44, 8'h33, 8'hff, 8'hf3, 8'h14, 8'h40};
        send_file();
        // One byte, no header: default rate
        file_bytes = '{8'h00};
        send_file();
        // Empty tag, header straight after it
        file_bytes = '{8'h49, 8'h44, 8'h33, 8'h03, 8'h00, 8'h00, 8'h00, 8'h00,
                       8'h00, 8'h00, 8'hff, 8'hfd, 8'he0, 8'hff};
        send_file();

        // Random phases, extremes and crossed limits among them
        apply_rates(16'd0, 16'd0, 16'd0);
        run_random_files(PHASE_BYTES);
        apply_rates(16'hffff, 16'hffff, 16'hffff);
        run_random_files(PHASE_BYTES);
        apply_rates(16'd9000, 16'd30000, 16'd10000);
        run_random_files(PHASE_BYTES);
        lo = 16'($urandom_range(0, 20000));
        apply_rates(16'($urandom), lo, 16'($urandom_range(lo, 16'hffff)));
        run_random_files(PHASE_BYTES);
        apply_rates(DEFAULT_RATE_RESET, MIN_RATE_RESET, MAX_RATE_RESET);
        run_random_files(PHASE_BYTES);
        apply_rates(16'($urandom), 16'($urandom), 16'($urandom));
        run_random_files(PHASE_BYTES);

        // Drain, let the pipe settle, then give the verdict
        hold_until_drained();
        repeat (SETTLE) @(posedge clk);
        if (tracker.mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/mfsbd_pkg.sv
sv/mfsbd_queue.sv
sv/mfsbd_front.sv
sv/mfsbd_back.sv
sv/mp3_frame_sync_bitrate_detector.sv
tb/sv/mp3_frame_sync_bitrate_detector_tb.sv
